// ===== design/aec_pkg.sv =====
package aec_pkg;

  // Luminance weights in Q0.8, they add up to 256
  localparam logic [6:0] W_RED   = 7'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [4:0] W_BLUE  = 5'd29;

  localparam logic [15:0] ONE_Q88       = 16'd256;
  localparam logic [15:0] HALF_DIVIDEND = 16'd32768;
  localparam logic [15:0] SAT_Q88       = 16'hFFFF;
  localparam logic [8:0]  WEIGHT_ONE    = 9'd256;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int MAX_SAMPLES_DEF   = 4096;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [15:0] THRESHOLD_RST = 16'd26;
  localparam logic [8:0]  WEIGHT_RST    = 9'd230;
  localparam logic [15:0] EXP_MIN_RST   = 16'd26;
  localparam logic [15:0] EXP_MAX_RST   = 16'd2560;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WEIGHT    = 2'd1,
    REG_EXP_MIN   = 2'd2,
    REG_EXP_MAX   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] change_threshold;
    logic [8:0]  memory_weight;
    logic [15:0] exposure_min;
    logic [15:0] exposure_max;
  } cfg_t;

endpackage

// ===== design/aec_ram.sv =====
module aec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

// ===== design/aec_fifo.sv =====
module aec_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [LW-1:0]    level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [LW-1:0]    level_r;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    adv = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= din;
        wp_r        <= adv(wp_r);
      end
      if (pop) begin
        rp_r <= adv(rp_r);
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign dout  = mem_r[rp_r];
  assign empty = (level_r == '0);
  assign level = level_r;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (level_r != LW'(DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");
`endif

endmodule

// ===== design/aec_div.sv =====
module aec_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quo
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
        rem_r  <= '0;
        quo_r  <= dvd;
        dvs_r  <= dvs;
      end else if (busy_r) begin
        rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== design/aec_front.sv =====
module aec_front #(
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = 13,
  parameter int SUM_W       = 29,
  parameter int LW          = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            in_red,
  input  logic [15:0]            in_green,
  input  logic [15:0]            in_blue,
  input  logic                   in_last_sample,
  input  logic [LW-1:0]          q_level,
  output logic                   q_push,
  output logic [SUM_W+CNT_W-1:0] q_din
);

  import aec_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             s1_valid_r, s1_last_r, s1_take_r;
  logic [15:0]      s1_luma_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic [SUM_W-1:0] sum_r, sum_add;
  logic [24:0]      acc;
  logic             accept, take;
  logic [LW:0]      pending;

  assign acc = 25'(W_RED) * 25'(in_red) + 25'(W_GREEN) * 25'(in_green)
             + 25'(W_BLUE) * 25'(in_blue) + 25'd128;

  // count a frame end still in the luma stage as already queued
  assign pending  = {1'b0, q_level} + (LW+1)'(s1_valid_r && s1_last_r);
  assign in_ready = (pending < (LW+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  assign take     = (cnt_r < CNT_W'(MAX_SAMPLES));
  assign cnt_nxt  = take ? cnt_r + 1'b1 : cnt_r;

  assign sum_add = sum_r + (s1_take_r ? SUM_W'(s1_luma_r) : '0);
  assign q_push  = s1_valid_r && s1_last_r;
  assign q_din   = {sum_add, s1_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        s1_last_r <= in_last_sample;
        s1_take_r <= take;
        s1_luma_r <= acc[23:8];
        s1_cnt_r  <= cnt_nxt;
        cnt_r     <= in_last_sample ? '0 : cnt_nxt;
      end
      if (s1_valid_r) begin
        sum_r <= s1_last_r ? '0 : sum_add;
      end
    end
  end

endmodule

// ===== design/aec_back.sv =====
module aec_back #(
  parameter int HISTORY_DEPTH = 16,
  parameter int CNT_W         = 13,
  parameter int SUM_W         = 29
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aec_pkg::cfg_t          cfg,
  input  logic                   q_empty,
  input  logic [SUM_W+CNT_W-1:0] q_dout,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_exposure,
  output logic [15:0]            out_average_luminance
);

  import aec_pkg::*;

  localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HS_W  = 16 + $clog2(HISTORY_DEPTH + 1);
  localparam int DVD_W = SUM_W;
  localparam int DVS_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int RL    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 0;
  localparam int RSH   = HS_W + RL;
  localparam int RW    = HS_W + 1;
  localparam int PW    = HS_W + RW;
  localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(HISTORY_DEPTH - 1))
                               / longint'(HISTORY_DEPTH);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  typedef enum logic [2:0] {
    S_IDLE, S_MEAN, S_TGT, S_HIST, S_AVG, S_MUL, S_BLEND
  } state_t;

  state_t             state_r;
  logic               cnt_zero_r;
  logic [15:0]        mean_r, target_r, cur_r, out_exp_r, out_avg_r, avg_r;
  logic               blend_r, out_valid_r;
  logic [24:0]        p1_r, p2_r;
  logic [SW-1:0]      slot_r;
  logic [HISTORY_DEPTH-1:0] hv_r;
  logic [HS_W-1:0]    hsum_r, hsum_new;
  logic               div_start_r, div_busy, div_done;
  logic [DVD_W-1:0]   div_dvd_r, div_quo;
  logic [DVS_W-1:0]   div_dvs_r;
  logic [15:0]        ram_q, old_val, quo16, diff, blended, lo_clamp, fin;
  logic [8:0]         w;
  logic [25:0]        bsum;
  logic [PW-1:0]      avg_prod;
  logic [SUM_W-1:0]   q_sum;
  logic [CNT_W-1:0]   q_cnt;

  assign q_sum = q_dout[SUM_W+CNT_W-1:CNT_W];
  assign q_cnt = q_dout[CNT_W-1:0];
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  aec_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .dvd   (div_dvd_r),
    .dvs   (div_dvs_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  aec_ram #(.WIDTH(16), .DEPTH(HISTORY_DEPTH), .AW(SW)) u_hist (
    .clk   (clk),
    .we    (state_r == S_HIST),
    .waddr (slot_r),
    .wdata (target_r),
    .re    (q_pop),
    .raddr (slot_r),
    .q     (ram_q)
  );

  // ring average by reciprocal multiply, exact for any sum the ring can hold
  assign avg_prod = PW'(hsum_r) * PW'(RECIP);

  assign quo16    = (|div_quo[DVD_W-1:16]) ? SAT_Q88 : div_quo[15:0];
  assign old_val  = hv_r[slot_r] ? ram_q : ONE_Q88;
  assign hsum_new = hsum_r - HS_W'(old_val) + HS_W'(target_r);
  assign diff     = (cur_r > avg_r) ? cur_r - avg_r : avg_r - cur_r;
  assign w        = (cfg.memory_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.memory_weight;
  assign bsum     = 26'(p1_r) + 26'(p2_r) + 26'd128;
  assign blended  = blend_r ? bsum[23:8] : cur_r;
  assign lo_clamp = (blended < cfg.exposure_min) ? cfg.exposure_min : blended;
  assign fin      = (lo_clamp > cfg.exposure_max) ? cfg.exposure_max : lo_clamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= ONE_Q88;
      slot_r      <= '0;
      hv_r        <= '0;
      hsum_r      <= HS_W'(256 * HISTORY_DEPTH);
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            div_start_r <= 1'b1;
            div_dvd_r   <= DVD_W'(q_sum);
            div_dvs_r   <= DVS_W'(q_cnt);
            cnt_zero_r  <= (q_cnt == '0);
            state_r     <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_r <= cnt_zero_r ? '0 : quo16;
            if (cnt_zero_r || quo16 == '0) begin
              target_r <= SAT_Q88;
              state_r  <= S_HIST;
            end else begin
              div_start_r <= 1'b1;
              div_dvd_r   <= DVD_W'(HALF_DIVIDEND);
              div_dvs_r   <= DVS_W'(quo16);
              state_r     <= S_TGT;
            end
          end
        end
        S_TGT: begin
          if (div_done) begin
            target_r <= quo16;
            state_r  <= S_HIST;
          end
        end
        S_HIST: begin
          hsum_r       <= hsum_new;
          hv_r[slot_r] <= 1'b1;
          slot_r       <= (slot_r == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          state_r      <= S_AVG;
        end
        S_AVG: begin
          avg_r   <= avg_prod[RSH +: 16];
          state_r <= S_MUL;
        end
        S_MUL: begin
          blend_r <= (diff > cfg.change_threshold);
          p1_r    <= 25'(w) * 25'(cur_r);
          p2_r    <= 25'(WEIGHT_ONE - w) * 25'(avg_r);
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            cur_r       <= fin;
            out_exp_r   <= fin;
            out_avg_r   <= mean_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_exposure          = out_exp_r;
  assign out_average_luminance = out_avg_r;

`ifndef ASSERT_OFF
  a_div_idle_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_BLEND) |-> !div_busy)
    else $error("divider busy outside a divide step");
`endif

endmodule

// ===== design/auto_exposure_controller_top.sv =====
// A sample passes the registered luma stage into the frame queue; per frame the back
//   end then runs the shared bit-serial divider, W = 16 + clog2(MAX_SAMPLES+1) bits
//   wide (mean, then target); a zero mean skips the target.
// Throughput: one sample per cycle while fewer than two frame ends wait in the
//   queue and the luma stage; short frames stall the input until the back end frees one.
// Reset (rst_n, synchronous, active low): registers at defaults, history 1.0.
module auto_exposure_controller_top
  import aec_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_red,
  input  logic [15:0]       in_green,
  input  logic [15:0]       in_blue,
  input  logic              in_last_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_exposure,
  output logic [15:0]       out_average_luminance,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int QW    = SUM_W + CNT_W;
  localparam int LW    = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg_r;
  reg_idx_t      idx;
  logic          q_push, q_pop, q_empty;
  logic [QW-1:0] q_din, q_dout;
  logic [LW-1:0] q_level;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.change_threshold <= THRESHOLD_RST;
      cfg_r.memory_weight    <= WEIGHT_RST;
      cfg_r.exposure_min     <= EXP_MIN_RST;
      cfg_r.exposure_max     <= EXP_MAX_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_THRESHOLD: cfg_r.change_threshold <= pwdata[15:0];
        REG_WEIGHT:    cfg_r.memory_weight    <= pwdata[8:0];
        REG_EXP_MIN:   cfg_r.exposure_min     <= pwdata[15:0];
        REG_EXP_MAX:   cfg_r.exposure_max     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = 32'(cfg_r.change_threshold);
      REG_WEIGHT:    prdata = 32'(cfg_r.memory_weight);
      REG_EXP_MIN:   prdata = 32'(cfg_r.exposure_min);
      REG_EXP_MAX:   prdata = 32'(cfg_r.exposure_max);
      default:       prdata = '0;
    endcase
  end

  aec_front #(.MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W), .SUM_W(SUM_W), .LW(LW)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_last_sample (in_last_sample),
    .q_level        (q_level),
    .q_push         (q_push),
    .q_din          (q_din)
  );

  aec_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH), .LW(LW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .level (q_level)
  );

  aec_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_empty               (q_empty),
    .q_dout                (q_dout),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_exposure          (out_exposure),
    .out_average_luminance (out_average_luminance)
  );

`ifndef ASSERT_OFF
  a_exp_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exposure <= cfg_r.exposure_max))
    else $error("exposure above upper clamp");
`endif

endmodule

// ===== bench/tb_auto_exposure_controller_top.sv =====
module tb_auto_exposure_controller_top;
  import aec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = 16;
  localparam int MAX_CNT = 4096;

  typedef struct {
    logic [15:0] exposure;
    logic [15:0] mean;
  } frame_result_t;

  class exposure_scoreboard;
    logic [15:0]   thr;
    logic [8:0]    weight;
    logic [15:0]   lo;
    logic [15:0]   hi;
    logic [27:0]   sum;
    logic [12:0]   count;
    logic [15:0]   ring[DEPTH];
    int unsigned   slot;
    logic [19:0]   ring_sum;
    logic [15:0]   cur;
    frame_result_t awaited[$];
    int            errors;

    function void init();
      thr = THRESHOLD_RST;
      weight = WEIGHT_RST;
      lo = EXP_MIN_RST;
      hi = EXP_MAX_RST;
      sum = '0;
      count = '0;
      for (int i = 0; i < DEPTH; i++) ring[i] = 16'd256;
      slot = 0;
      ring_sum = 20'(256 * DEPTH);
      cur = 16'd256;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_THRESHOLD: thr = val[15:0];
        REG_WEIGHT:    weight = val[8:0];
        REG_EXP_MIN:   lo = val[15:0];
        REG_EXP_MAX:   hi = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_input(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
      logic [31:0] acc;
      logic [31:0] mean, target, avg, diff, w, nxt;
      frame_result_t res;
      acc = 32'd77 * r + 32'd150 * g + 32'd29 * b + 32'd128;
      if (count < MAX_CNT) begin
        sum = sum + 28'(acc[23:8]);
        count = count + 13'd1;
      end
      if (!last) return;
      mean = (count != 0) ? 32'(sum) / 32'(count) : 32'd0;
      if (mean > 32'hFFFF) mean = 32'hFFFF;
      target = (mean == 0) ? 32'hFFFF : 32'd32768 / mean;
      ring_sum = ring_sum - 20'(ring[slot]) + 20'(target[15:0]);
      ring[slot] = target[15:0];
      slot = (slot + 1) % DEPTH;
      avg = 32'(ring_sum) / DEPTH;
      nxt = 32'(cur);
      diff = (nxt > avg) ? nxt - avg : avg - nxt;
      if (diff > thr) begin
        w = (weight > 256) ? 32'd256 : 32'(weight);
        nxt = (w * nxt + (32'd256 - w) * avg + 32'd128) >> 8;
      end
      if (nxt < lo) nxt = 32'(lo);
      if (nxt > hi) nxt = 32'(hi);
      cur = nxt[15:0];
      sum = '0;
      count = '0;
      res.exposure = cur;
      res.mean = mean[15:0];
      awaited.insert(awaited.size(), res);
    endfunction

    function void check_result(logic [15:0] exposure, logic [15:0] mean);
      frame_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result word exposure=%0d average_luminance=%0d", exposure, mean);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (exposure !== want.exposure) begin
        $error("exposure: expected %0d, got %0d", want.exposure, exposure);
        errors++;
      end
      if (mean !== want.mean) begin
        $error("average_luminance: expected %0d, got %0d", want.mean, mean);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_red = '0, in_green = '0, in_blue = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_exposure, out_average_luminance;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  exposure_scoreboard sb;
  bit no_idle = 1'b0;

  auto_exposure_controller_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_exposure(out_exposure), .out_average_luminance(out_average_luminance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check at the edge, pick the next ready at the falling edge
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_exposure, out_average_luminance);
      @(negedge clk);
      out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 23);
    end
  end

  task automatic send_word(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_red = r;
    in_green = g;
    in_blue = b;
    in_last_sample = last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(r, g, b, last);
    @(negedge clk);
  endtask

  task automatic send_frame(int len, int kind);
    logic [15:0] r, g, b;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: begin r = 16'($urandom); g = 16'($urandom); b = 16'($urandom); end
        1: begin r = 16'($urandom_range(0, 1023)); g = 16'($urandom_range(0, 1023));
                 b = 16'($urandom_range(0, 1023)); end
        default: begin r = 16'($urandom_range(0, 3)); g = 16'($urandom_range(0, 3));
                       b = 16'($urandom_range(0, 3)); end
      endcase
      send_word(r, g, b, i == len - 1);
    end
  endtask

  // hold off until every frame result is out, then let the back end settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_W'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_all(logic [31:0] t, logic [31:0] w, logic [31:0] mn, logic [31:0] mx);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_WEIGHT, w);
    write_reg(REG_EXP_MIN, mn);
    write_reg(REG_EXP_MAX, mx);
  endtask

  initial begin
    int sent;
    sb = new();
    sb.init();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, zero mean, plain frames under reset settings
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_word(16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0100, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h0000, 16'h0100, 1'b1);
    send_word(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    send_word(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    drain();
    // weight above one, no clamps, zero threshold
    set_all(0, 511, 0, 16'hFFFF);
    send_word(16'h0040, 16'h0040, 16'h0040, 1'b1);
    send_word(16'h0040, 16'h0040, 16'h0040, 1'b1);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();
    // crossed clamps, max threshold, zero weight
    set_all(16'hFFFF, 0, 3000, 100);
    send_word(16'h0010, 16'h0020, 16'h0030, 1'b1);
    send_word(16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();
    set_all(1, 0, 0, 16'hFFFF);
    send_word(16'h0001, 16'h0001, 16'h0001, 1'b1);
    send_word(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_word(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    drain();
    // sample count saturation
    no_idle = 1'b1;
    send_frame(MAX_CNT + 5, 0);
    no_idle = 1'b0;
    drain();

    // random phases
    sent = 0;
    for (int ph = 0; sent < 450; ph++) begin
      case (ph % 5)
        0: set_all($urandom_range(0, 64), $urandom_range(0, 256),
                   $urandom_range(0, 300), $urandom_range(2000, 65535));
        1: set_all(0, 256, 0, 65535);
        2: set_all($urandom, $urandom_range(0, 511), $urandom, $urandom);
        3: set_all($urandom_range(0, 8), $urandom_range(200, 511),
                   $urandom_range(0, 50), $urandom_range(100, 20000));
        default: set_all(65535, 0, 65535, 0);
      endcase
      no_idle = (ph == 2);
      for (int f = 0; f < 12; f++) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        send_frame(len, $urandom_range(2));
        sent += len;
        if (f == 5 && ph == 1) drain();
      end
      no_idle = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== auto_exposure_controller_top.f =====
design/aec_pkg.sv
design/aec_ram.sv
design/aec_fifo.sv
design/aec_div.sv
design/aec_front.sv
design/aec_back.sv
design/auto_exposure_controller_top.sv
bench/tb_auto_exposure_controller_top.sv
